@@ rtl/isqrt_pkg.sv @@
// Shared constants for the integer square root pipeline.
package isqrt_pkg;

  // Default datapath width of the radicand.
  localparam int DEF_WIDTH = 64;

  // Fixed port widths of the radicand and root fields.
  localparam int IN_W  = 64;
  localparam int OUT_W = 32;

endpackage

@@ rtl/isqrt_step.sv @@
// One registered compare-subtract step of the digit-by-digit square root.
module isqrt_step import isqrt_pkg::*; #(
  parameter int WIDTH     = DEF_WIDTH,
  parameter int TRIAL_POS = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] root_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] root_o
);

  localparam logic [WIDTH-1:0] TRIAL = {{(WIDTH-1){1'b0}}, 1'b1} << TRIAL_POS;

  logic             valid_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] root_r;
  logic [WIDTH-1:0] cand;
  logic             fits;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] root_nxt;

  // Compare the remainder with trial bit OR partial root; reduce when it fits
  always_comb begin
    cand     = TRIAL | root_i;
    fits     = (rem_i >= cand);
    rem_nxt  = fits ? (rem_i - cand) : rem_i;
    root_nxt = (root_i >> 1) | (fits ? TRIAL : '0);
  end

  // Advance the valid bit; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;

endmodule

@@ rtl/integer_square_root.sv @@
// Top level of the pipelined integer square root.
//
// Pulse start with a signed radicand on in_radicand while busy is low; the
// floor of its square root appears on out_root with a one-cycle out_valid
// strobe after the input register and the STEPS steps, where STEPS = (WIDTH-2)/2
// + 1. One beat can enter every cycle that busy is low: each pipeline stage holds one
// compare-subtract of the WIDTH-bit remainder, plus one input register stage.
// Zero and negative radicands give 0; bits above WIDTH-1 are ignored. Results
// are never held back, so the receiver must take every strobe. busy is high
// during reset and until the first clock edge after reset is released.
module integer_square_root import isqrt_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [IN_W-1:0] in_radicand,
  output logic                   busy,
  output logic                   out_valid,
  output logic [OUT_W-1:0]       out_root
);

  localparam int TOP   = ((WIDTH - 2) / 2) * 2;
  localparam int STEPS = TOP / 2 + 1;

  logic             busy_r;
  logic             valid0_r;
  logic [WIDTH-1:0] rem0_r;
  logic [WIDTH-1:0] rem0_nxt;
  logic [WIDTH-1:0] value;

  logic             valid_s [0:STEPS];
  logic [WIDTH-1:0] rem_s   [0:STEPS];
  logic [WIDTH-1:0] root_s  [0:STEPS];

  // Hold busy high through reset; clear it on the first clock edge out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Drop the sign: a negative radicand starts with zero remainder
  always_comb begin
    value    = in_radicand[WIDTH-1:0];
    rem0_nxt = value[WIDTH-1] ? '0 : value;
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else begin
      valid0_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    rem0_r <= rem0_nxt;
  end

  assign valid_s[0] = valid0_r;
  assign rem_s[0]   = rem0_r;
  assign root_s[0]  = '0;

  // One stage per trial bit, top position first
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    isqrt_step #(
      .WIDTH     (WIDTH),
      .TRIAL_POS (TOP - 2 * k)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_s[k]),
      .rem_i   (rem_s[k]),
      .root_i  (root_s[k]),
      .valid_o (valid_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .root_o  (root_s[k+1])
    );
  end

  assign out_valid = valid_s[STEPS];
  assign out_root  = OUT_W'(root_s[STEPS]);

endmodule

@@ rtl/isqrt_checker.sv @@
// Port-level checker for the integer square root, bound to the top level.
module isqrt_checker import isqrt_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic signed [IN_W-1:0] in_radicand,
  input logic                   busy,
  input logic                   out_valid,
  input logic [OUT_W-1:0]       out_root
);

  localparam int LAT = ((WIDTH - 2) / 2) + 2;
  localparam int SQ_W = 2 * OUT_W + 2;

  // Every accepted beat yields a strobe on out_valid
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat produced no result");

  // No strobe without an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted beat");

  // Negative radicand gives zero
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_radicand[WIDTH-1]) |-> ##LAT (out_root == '0))
    else $error("negative radicand gave nonzero root");

  // Root squared stays at or below the radicand
  a_floor_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(in_radicand[WIDTH-1], LAT)) |->
      (SQ_W'(out_root) * SQ_W'(out_root) <= SQ_W'($past(in_radicand[WIDTH-1:0], LAT))))
    else $error("root too large");

  // Next integer squared exceeds the radicand
  a_floor_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(in_radicand[WIDTH-1], LAT)) |->
      ((SQ_W'(out_root) + SQ_W'(1)) * (SQ_W'(out_root) + SQ_W'(1)) >
       SQ_W'($past(in_radicand[WIDTH-1:0], LAT))))
    else $error("root too small");

endmodule

bind integer_square_root isqrt_checker #(.WIDTH(WIDTH)) u_isqrt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .in_radicand (in_radicand),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_root    (out_root)
);
